FILE: rtl/ple_pkg.sv
// Package for the Potts lattice energy block: sizes, register indexes, sequencer states.
// No dependencies; used by the top level and the checker of the block.
package ple_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int SPIN_BITS = 8;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int POS_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = 7;
    localparam int J_W       = 16;
    localparam int BOND_W    = 14;
    localparam int ENERGY_W  = 30;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING    = 1'b1;

    localparam logic [SIDE_W-1:0] SIDE_RESET     = 7'd64;
    localparam logic [J_W-1:0]    COUPLING_RESET = 16'd256;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_HERE,
        S_RD_RIGHT,
        S_RD_DOWN,
        S_CMP_DOWN,
        S_MUL,
        S_OUT
    } t_state;

endpackage

FILE: rtl/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module ple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/potts_lattice_energy.sv
// Top level of the Potts lattice energy block: spin store, scan sequencer, output register.
// Depends on ple_pkg and ple_ram.
//
// Spins of one side x side periodic lattice stream in row-major order, one item per
// cycle while tready is high, with tlast on the final spin. The closing item starts a
// scan over the stored lattice: each cell in turn takes the single read port of the spin
// store (read the cell, its right and its down neighbour, then compare), and the input
// is held off during the scan. The result item carries the number of equal right/down
// neighbour pairs and energy = -J * pairs in signed Q22.8, with J in Q8.8. If the spin
// count does not match side^2 (or side is 0 or above 64), status is set and both
// numbers are zero, and no scan is run.
module potts_lattice_energy (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ple_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ple_pkg::J_W-1:0]         i_cfg_data,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ple_pkg::IN_DATA_W-1:0]   i_s_tdata,   // [7:0] spin
    input  logic                            i_s_tlast,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ple_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // [13:0] equal_bonds, [43:14] energy
    output logic                            o_m_tuser    // [0] status
);
    import ple_pkg::*;

    t_state r_state, n_state;

    logic [SIDE_W-1:0]    r_side;
    logic [J_W-1:0]       r_coupling;
    logic [CNT_W-1:0]     r_load_count;
    logic [POS_W-1:0]     r_col, r_row;
    logic [ADDR_W-1:0]    r_row_base;
    logic [CNT_W-1:0]     r_down_base;
    logic [SPIN_BITS-1:0] r_here;
    logic [BOND_W-1:0]    r_bonds;
    logic [ENERGY_W-1:0]  r_energy;
    logic                 r_status;
    logic                 r_m_valid;
    logic [BOND_W-1:0]    r_m_bonds;
    logic [ENERGY_W-1:0]  r_m_energy;
    logic                 r_m_status;

    logic                 w_accept;
    logic                 w_ram_we;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic [SPIN_BITS-1:0] w_rd_data;
    logic [CNT_W-1:0]     w_count_next;
    logic [2*SIDE_W-1:0]  w_side_sq;
    logic                 w_mismatch;
    logic                 w_col_last, w_row_last;
    logic                 w_out_free;
    logic [ADDR_W-1:0]    w_here_addr, w_right_addr, w_down_addr;
    logic signed [J_W:0]  w_neg_j;
    logic signed [31:0]   w_prod;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    // count saturates at capacity + 1 so an overlong lattice still mismatches
    assign w_count_next = (r_load_count == CNT_W'(DEPTH + 1)) ? r_load_count
                                                               : r_load_count + 1'b1;
    assign w_side_sq  = r_side * r_side;
    assign w_mismatch = (r_side == '0) || (r_side > SIDE_W'(MAX_SIDE)) ||
                        (w_count_next != CNT_W'(w_side_sq));

    assign w_col_last = (SIDE_W'(r_col) + 1'b1) == r_side;
    assign w_row_last = (SIDE_W'(r_row) + 1'b1) == r_side;

    assign w_here_addr  = r_row_base + ADDR_W'(r_col);
    assign w_right_addr = w_col_last ? r_row_base : w_here_addr + 1'b1;
    assign w_down_addr  = w_row_last ? ADDR_W'(r_col)
                                     : r_down_base[ADDR_W-1:0] + ADDR_W'(r_col);

    assign w_neg_j = -$signed({r_coupling[J_W-1], r_coupling});
    assign w_prod  = w_neg_j * $signed({1'b0, r_bonds});

    ple_ram #(
        .WIDTH (SPIN_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_wr_addr (r_load_count[ADDR_W-1:0]),
        .i_wr_data (i_s_tdata[SPIN_BITS-1:0]),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_s_tlast) begin
                    n_state = w_mismatch ? S_OUT : S_RD_HERE;
                end
            end
            S_RD_HERE:  n_state = S_RD_RIGHT;
            S_RD_RIGHT: n_state = S_RD_DOWN;
            S_RD_DOWN:  n_state = S_CMP_DOWN;
            S_CMP_DOWN: n_state = (w_col_last && w_row_last) ? S_MUL : S_RD_HERE;
            S_MUL:      n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_LOAD;
                end
            end
            default:    n_state = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_ram_we   = 1'b0;
        w_rd_addr  = w_here_addr;
        case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                w_ram_we   = i_s_tvalid && !r_load_count[CNT_W-1];
            end
            S_RD_HERE:  w_rd_addr = w_here_addr;
            S_RD_RIGHT: w_rd_addr = w_right_addr;
            S_RD_DOWN:  w_rd_addr = w_down_addr;
            default:    w_rd_addr = w_here_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_side       <= SIDE_RESET;
            r_coupling   <= COUPLING_RESET;
            r_load_count <= '0;
            r_bonds      <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SIDE_LENGTH: r_side     <= i_cfg_data[SIDE_W-1:0];
                    CFG_COUPLING:    r_coupling <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_load_count <= i_s_tlast ? '0 : w_count_next;
                        if (i_s_tlast) begin
                            r_bonds <= '0;
                        end
                    end
                end
                S_RD_DOWN: begin
                    if (w_rd_data == r_here) begin
                        r_bonds <= r_bonds + 1'b1;
                    end
                end
                S_CMP_DOWN: begin
                    if (w_rd_data == r_here) begin
                        r_bonds <= r_bonds + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_bonds <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_s_tlast) begin
                    r_col       <= '0;
                    r_row       <= '0;
                    r_row_base  <= '0;
                    r_down_base <= CNT_W'(r_side);
                    r_status    <= w_mismatch;
                    r_energy    <= '0;
                end
            end
            S_RD_RIGHT: r_here <= w_rd_data;
            S_CMP_DOWN: begin
                if (w_col_last) begin
                    r_col       <= '0;
                    r_row       <= r_row + 1'b1;
                    r_row_base  <= r_down_base[ADDR_W-1:0];
                    r_down_base <= r_down_base + CNT_W'(r_side);
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            S_MUL: r_energy <= w_prod[ENERGY_W-1:0];
            S_OUT: begin
                if (w_out_free) begin
                    r_m_bonds  <= r_bonds;
                    r_m_energy <= r_energy;
                    r_m_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(OUT_DATA_W - BOND_W - ENERGY_W)'(0), r_m_energy, r_m_bonds};
    assign o_m_tuser  = r_m_status;

endmodule

FILE: rtl/ple_checker.sv
// Port-level checks for potts_lattice_energy, attached by bind.
// Depends on ple_pkg.
module ple_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [ple_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic                            o_m_tuser
);
    import ple_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // an error result carries zero numbers
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("error result with nonzero fields");

    // no pairs means no energy
    a_zero_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[BOND_W-1:0] == '0 |->
            o_m_tdata[BOND_W+ENERGY_W-1:BOND_W] == '0)
        else $error("energy without equal pairs");

    // the closing item takes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after closing item");

endmodule

bind potts_lattice_energy ple_checker u_ple_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for potts_lattice_energy: streams periodic spin lattices,
// predicts equal-bond counts and Q22.8 energies, and checks every result item.
// Depends on ple_pkg and the potts_lattice_energy RTL.
module tb_top;
    import ple_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [BOND_W-1:0]   bonds;
        logic [ENERGY_W-1:0] energy;
        logic                status;
    } t_lattice_result;

    typedef struct {
        bit                  new_cfg;
        logic [SIDE_W-1:0]   side;
        logic [J_W-1:0]      coupling;
        logic [7:0]          spin;
        logic                last;
        bit                  typed;
        logic [BOND_W-1:0]   bonds;
        logic [ENERGY_W-1:0] energy;
        logic                status;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [J_W-1:0]         i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;    // [7:0] spin
    logic                   i_s_tlast = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;         // [13:0] equal_bonds, [43:14] energy
    logic                   o_m_tuser;         // [0] status

    // predictor state
    logic [7:0]             spin_mem [DEPTH];
    int                     load_cnt = 0;
    logic [SIDE_W-1:0]      cfg_side = SIDE_RESET;
    logic signed [J_W-1:0]  cfg_coupling = COUPLING_RESET;

    t_lattice_result        expected_results [$];
    int                     errors = 0;
    bit                     quiet = 1'b0;
    int                     sink_stall = 0;

    potts_lattice_energy u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // right and down neighbour of every cell, both with wrap-around
    function automatic int count_equal_pairs(int side);
        int acc;
        int dn;
        int rt;
        logic [7:0] here;
        acc = 0;
        for (int r = 0; r < side; r++) begin
            dn = (r + 1 == side) ? 0 : r + 1;
            for (int c = 0; c < side; c++) begin
                rt = (c + 1 == side) ? 0 : c + 1;
                here = spin_mem[r * side + c];
                if (spin_mem[r * side + rt] == here) acc++;
                if (spin_mem[dn * side + c] == here) acc++;
            end
        end
        return acc;
    endfunction

    function automatic void queue_expected(input t_lattice_result res_in);
        expected_results = {expected_results, res_in};
    endfunction

    function automatic void absorb_spin(input logic [7:0] s, input logic l,
                                        output bit closed, output t_lattice_result res);
        int pairs;
        int side;
        longint e;
        closed = l;
        res = '0;
        side = cfg_side;
        // drop spins past capacity, count saturates one above it
        if (load_cnt < DEPTH) spin_mem[load_cnt] = s;
        if (load_cnt <= DEPTH) load_cnt++;
        if (!l) return;
        if (side == 0 || side > MAX_SIDE || load_cnt != side * side) begin
            res.status = 1'b1;
        end else begin
            pairs = count_equal_pairs(side);
            e = -longint'(cfg_coupling) * longint'(pairs);
            res.bonds = pairs[BOND_W-1:0];
            res.energy = e[ENERGY_W-1:0];
        end
        load_cnt = 0;
    endfunction

    task automatic feed_spin(input logic [7:0] s, input logic l, input bit typed,
                             input t_lattice_result typed_res);
        int gap;
        bit rdy;
        bit closed;
        t_lattice_result res;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= s;
        i_s_tlast <= l;
        // sample ready mid-cycle, the item moves at the following edge
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
        end while (!rdy);
        absorb_spin(s, l, closed, res);
        if (closed) queue_expected(typed ? typed_res : res);
    endtask

    task automatic settle_block();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_lattice_cfg(input logic [SIDE_W-1:0] side, input logic [J_W-1:0] j);
        logic [J_W-1:0] junk;
        junk = J_W'($urandom);
        // upper data bits are don't-care for the side register
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_SIDE_LENGTH;
        i_cfg_data <= {junk[J_W-1:SIDE_W], side};
        @(posedge i_clk);
        i_cfg_addr <= CFG_COUPLING;
        i_cfg_data <= j;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_side = side;
        cfg_coupling = j;
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            i_m_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else begin
            i_m_tready <= 1'b1;
            sink_stall <= pick_gap();
        end
    end

    always @(negedge i_clk) begin : result_check
        t_lattice_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result item, tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[BOND_W-1:0] !== want.bonds) begin
                    $display("%0t: equal_bonds expected %0d actual %0d",
                             $time, want.bonds, o_m_tdata[BOND_W-1:0]);
                    errors++;
                end
                if (o_m_tdata[BOND_W+ENERGY_W-1:BOND_W] !== want.energy) begin
                    $display("%0t: energy expected %h actual %h",
                             $time, want.energy, o_m_tdata[BOND_W+ENERGY_W-1:BOND_W]);
                    errors++;
                end
                if (o_m_tdata[OUT_DATA_W-1:BOND_W+ENERGY_W] !== '0) begin
                    $display("%0t: tdata pad expected 0 actual %h",
                             $time, o_m_tdata[OUT_DATA_W-1:BOND_W+ENERGY_W]);
                    errors++;
                end
                if (o_m_tuser !== want.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("potts_lattice_energy test failed");
        $finish;
    end

    t_stim_row directed_rows [24] = '{
        // reset side of 64 cannot match a single spin
        '{1'b0, 7'd0,   16'h0000, 8'hFF, 1'b1, 1'b1, 14'd0, 30'd0,         1'b1},
        // one cell pairs with itself right and down
        '{1'b1, 7'd1,   16'h8000, 8'hA5, 1'b1, 1'b1, 14'd2, 30'd65536,     1'b0},
        '{1'b1, 7'd2,   16'h7FFF, 8'h00, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'h00, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'h00, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'h00, 1'b1, 1'b1, 14'd8, -30'sd262136,  1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'hFF, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'h00, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'hFF, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd2,   16'h7FFF, 8'h00, 1'b1, 1'b0, 14'd0, 30'd0,         1'b0},
        // side zero, side above the store, side with every bit set
        '{1'b1, 7'd0,   16'h0000, 8'h12, 1'b1, 1'b1, 14'd0, 30'd0,         1'b1},
        '{1'b1, 7'd127, 16'h0100, 8'h34, 1'b1, 1'b1, 14'd0, 30'd0,         1'b1},
        '{1'b1, 7'd65,  16'hFFFF, 8'h56, 1'b1, 1'b1, 14'd0, 30'd0,         1'b1},
        // short lattice, then a full 3 x 3 one
        '{1'b1, 7'd3,   16'h0100, 8'h11, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h22, 1'b1, 1'b1, 14'd0, 30'd0,         1'b1},
        '{1'b0, 7'd3,   16'h0100, 8'h80, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h01, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h80, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h01, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h80, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h01, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h80, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h80, 1'b0, 1'b0, 14'd0, 30'd0,         1'b0},
        '{1'b0, 7'd3,   16'h0100, 8'h01, 1'b1, 1'b0, 14'd0, 30'd0,         1'b0}
    };

    initial begin
        int random_items;
        int side;
        int n;
        int k;
        int r;
        logic [7:0] base;
        logic [7:0] sp;
        logic [J_W-1:0] j;
        t_lattice_result typed_res;
        t_lattice_result none;

        none = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].new_cfg) begin
                settle_block();
                set_lattice_cfg(directed_rows[i].side, directed_rows[i].coupling);
            end
            typed_res.bonds = directed_rows[i].bonds;
            typed_res.energy = directed_rows[i].energy;
            typed_res.status = directed_rows[i].status;
            feed_spin(directed_rows[i].spin, directed_rows[i].last,
                      directed_rows[i].typed, typed_res);
        end
        settle_block();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 75) side = $urandom_range(1, 4);
            else if (r < 93) side = $urandom_range(5, 10);
            else if (r < 96) side = 0;
            else side = $urandom_range(65, 127);
            r = $urandom_range(0, 99);
            if (r < 15) j = 16'h8000;
            else if (r < 30) j = 16'h7FFF;
            else if (r < 40) j = 16'h0000;
            else j = J_W'($urandom);
            quiet = ($urandom_range(0, 3) == 0);
            set_lattice_cfg(side[SIDE_W-1:0], j);

            repeat ($urandom_range(1, 4)) begin
                r = $urandom_range(0, 3);
                k = (r == 0) ? 1 : (r == 1) ? 2 : (r == 2) ? 4 : 256;
                base = 8'($urandom);
                if (side == 0 || side > MAX_SIDE) begin
                    n = $urandom_range(1, 5);
                end else if ($urandom_range(0, 9) < 8) begin
                    n = side * side;
                end else begin
                    // broken lattice: anything but the right count
                    n = $urandom_range(1, side * side + 3);
                    if (n == side * side) n++;
                end
                for (int i = 0; i < n; i++) begin
                    sp = base + 8'($urandom_range(0, k - 1));
                    feed_spin(sp, i == n - 1, 1'b0, none);
                end
                random_items += n;
            end

            // leave a stray fragment to run into the next setting
            if ($urandom_range(0, 19) == 0) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) feed_spin(8'($urandom), 1'b0, 1'b0, none);
                random_items += n;
            end
            settle_block();
        end

        settle_block();
        if (errors == 0) begin
            $display("potts_lattice_energy test passed");
        end else begin
            $display("potts_lattice_energy test failed");
        end
        $finish;
    end

endmodule
